// File: rtl/sbeu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeu_pkg: shared types and constants
// Request/result transaction structs, opcodes and status codes.
// ----------------------------------------------------------------------------
package sbeu_pkg;

  typedef enum logic [1:0] {
    REQ_EXEC  = 2'd0,
    REQ_WRLOC = 2'd1,
    REQ_PUSH  = 2'd2,
    REQ_NONE  = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_BADLOC  = 3'd4,
    ST_CALL    = 3'd5
  } status_t;

  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_ACONST   = 8'h01;
  localparam logic [7:0] OP_ICM1     = 8'h02;
  localparam logic [7:0] OP_IC5      = 8'h08;
  localparam logic [7:0] OP_BIPUSH   = 8'h10;
  localparam logic [7:0] OP_SIPUSH   = 8'h11;
  localparam logic [7:0] OP_ILOAD0   = 8'h1A;
  localparam logic [7:0] OP_ILOAD2   = 8'h1C;
  localparam logic [7:0] OP_ISTORE   = 8'h36;
  localparam logic [7:0] OP_ISTORE0  = 8'h3B;
  localparam logic [7:0] OP_ISTORE3  = 8'h3E;
  localparam logic [7:0] OP_IADD     = 8'h60;
  localparam logic [7:0] OP_ISUB     = 8'h64;
  localparam logic [7:0] OP_IFGE     = 8'hA2;
  localparam logic [7:0] OP_IFGT     = 8'hA3;
  localparam logic [7:0] OP_IRETURN  = 8'hAC;
  localparam logic [7:0] OP_RETURN   = 8'hB1;
  localparam logic [7:0] OP_INVOKE   = 8'hB8;

  // Micro-operation chosen by the front end
  typedef enum logic [3:0] {
    UOP_NONE, UOP_PUSH_IMM, UOP_PUSH_LOC, UOP_STORE, UOP_ADD, UOP_SUB,
    UOP_CMPGE, UOP_CMPGT, UOP_IRET, UOP_RET, UOP_CALL, UOP_WRLOC,
    UOP_UNKNOWN, UOP_BADLOC
  } uop_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  opcode;
    logic [7:0]  operand_hi;
    logic [7:0]  operand_lo;
    logic [7:0]  slot_index;
    logic signed [31:0] slot_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  instr_length;
    logic        branch_taken;
    logic signed [15:0] branch_offset;
    logic        done_res;
    logic        return_valid;
    logic signed [31:0] return_value;
    logic [15:0] call_index;
    logic [2:0]  status;
  } res_t;

  // Decoded command between front and back end
  typedef struct packed {
    uop_t        uop;
    logic [1:0]  len;
    logic [7:0]  idx;
    logic [15:0] word;
    logic [31:0] imm;
  } cmd_t;

endpackage

// File: rtl/sbeu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeu_decode: front end
// Classifies a request into a micro-operation with its immediate data.
// ----------------------------------------------------------------------------
module sbeu_decode import sbeu_pkg::*; #(
  parameter int LOCAL_COUNT = 16
) (
  input  req_t req,
  output cmd_t cmd
);

  always_comb begin
    cmd.uop  = UOP_NONE;
    cmd.len  = 2'd0;
    cmd.idx  = 8'd0;
    cmd.word = {req.operand_hi, req.operand_lo};
    cmd.imm  = req.slot_value;
    unique case (req.req_type)
      REQ_WRLOC: begin
        cmd.idx = req.slot_index;
        cmd.uop = (32'(req.slot_index) < LOCAL_COUNT) ? UOP_WRLOC : UOP_BADLOC;
      end
      REQ_PUSH: cmd.uop = UOP_PUSH_IMM;
      REQ_EXEC: begin
        cmd.len = 2'd1;
        priority if (req.opcode == OP_NOP) begin
          cmd.uop = UOP_NONE;
        end else if (req.opcode == OP_ACONST) begin
          cmd.uop = UOP_PUSH_IMM;
          cmd.imm = 32'd0;
        end else if (req.opcode >= OP_ICM1 && req.opcode <= OP_IC5) begin
          cmd.uop = UOP_PUSH_IMM;
          cmd.imm = 32'(req.opcode) - 32'd3;
        end else if (req.opcode == OP_BIPUSH) begin
          cmd.len = 2'd2;
          cmd.uop = UOP_PUSH_IMM;
          cmd.imm = {{24{req.operand_hi[7]}}, req.operand_hi};
        end else if (req.opcode == OP_SIPUSH) begin
          cmd.len = 2'd3;
          cmd.uop = UOP_PUSH_IMM;
          cmd.imm = {{16{req.operand_hi[7]}}, req.operand_hi, req.operand_lo};
        end else if (req.opcode >= OP_ILOAD0 && req.opcode <= OP_ILOAD2) begin
          cmd.idx = req.opcode - OP_ILOAD0;
          cmd.uop = (32'(cmd.idx) < LOCAL_COUNT) ? UOP_PUSH_LOC : UOP_BADLOC;
        end else if (req.opcode == OP_ISTORE) begin
          cmd.len = 2'd2;
          cmd.idx = req.operand_hi;
          cmd.uop = (32'(cmd.idx) < LOCAL_COUNT) ? UOP_STORE : UOP_BADLOC;
        end else if (req.opcode >= OP_ISTORE0 && req.opcode <= OP_ISTORE3) begin
          cmd.idx = req.opcode - OP_ISTORE0;
          cmd.uop = (32'(cmd.idx) < LOCAL_COUNT) ? UOP_STORE : UOP_BADLOC;
        end else if (req.opcode == OP_IADD) begin
          cmd.uop = UOP_ADD;
        end else if (req.opcode == OP_ISUB) begin
          cmd.uop = UOP_SUB;
        end else if (req.opcode == OP_IFGE) begin
          cmd.len = 2'd3;
          cmd.uop = UOP_CMPGE;
        end else if (req.opcode == OP_IFGT) begin
          cmd.len = 2'd3;
          cmd.uop = UOP_CMPGT;
        end else if (req.opcode == OP_IRETURN) begin
          cmd.uop = UOP_IRET;
        end else if (req.opcode == OP_RETURN) begin
          cmd.uop = UOP_RET;
        end else if (req.opcode == OP_INVOKE) begin
          cmd.len = 2'd3;
          cmd.uop = UOP_CALL;
        end else begin
          cmd.uop = UOP_UNKNOWN;
        end
      end
      default: cmd.uop = UOP_NONE;
    endcase
  end

endmodule

// File: rtl/sbeu_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeu_fifo: small register queue
// Two-entry FIFO of generic width used between stages.
// ----------------------------------------------------------------------------
module sbeu_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= din;
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop)  rptr <= ~rptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: rtl/sbeu_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbeu_exec: back end
// Carries out one command per cycle, while the result queue is not full, on the operand stack and locals.
// ----------------------------------------------------------------------------
module sbeu_exec import sbeu_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int LOCAL_COUNT = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  output logic res_valid,
  output res_t res,
  input  logic res_full
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int LW = $clog2(LOCAL_COUNT);

  logic [31:0]   stk [STACK_DEPTH];
  logic [31:0]   loc [LOCAL_COUNT];
  logic [DW-1:0] depth, depth_next;
  logic [31:0]   top, nxt, lval, sum, dif;
  logic          can_push, has1, has2, fire, ge, gt;
  logic [LW-1:0] li;
  logic [DW-1:0] dm1, dm2;

  assign fire     = cmd_valid && !res_full;
  assign cmd_take = fire;
  assign li       = cmd.idx[LW-1:0];
  assign dm1      = depth - DW'(1);
  assign dm2      = depth - DW'(2);
  assign top      = stk[dm1[SW-1:0]];
  assign nxt      = stk[dm2[SW-1:0]];
  assign lval     = loc[li];
  assign can_push = 32'(depth) < STACK_DEPTH;
  assign has1     = depth != '0;
  assign has2     = 32'(depth) >= 2;
  assign sum      = nxt + top;
  assign dif      = nxt - top;
  assign ge       = $signed(nxt) >= $signed(top);
  assign gt       = $signed(nxt) > $signed(top);

  // Result and next depth
  always_comb begin
    res              = '0;
    res.instr_length = cmd.len;
    res.status       = ST_OK;
    depth_next       = depth;
    unique case (cmd.uop)
      UOP_PUSH_IMM, UOP_PUSH_LOC: begin
        if (can_push) depth_next = depth + DW'(1);
        else res.status = ST_OVER;
      end
      UOP_STORE, UOP_IRET: begin
        if (has1) depth_next = dm1;
        else res.status = ST_UNDER;
        if (has1 && cmd.uop == UOP_IRET) begin
          res.done_res     = 1'b1;
          res.return_valid = 1'b1;
          res.return_value = top;
        end
      end
      UOP_ADD, UOP_SUB: begin
        if (has2) depth_next = dm1;
        else res.status = ST_UNDER;
      end
      UOP_CMPGE, UOP_CMPGT: begin
        if (has2) begin
          depth_next       = dm2;
          res.branch_taken = (cmd.uop == UOP_CMPGE) ? ge : gt;
          if (res.branch_taken) res.branch_offset = cmd.word;
        end else begin
          res.status = ST_UNDER;
        end
      end
      UOP_RET:     res.done_res = 1'b1;
      UOP_CALL: begin
        res.call_index = cmd.word;
        res.status     = ST_CALL;
      end
      UOP_UNKNOWN: res.status = ST_UNKNOWN;
      UOP_BADLOC:  res.status = ST_BADLOC;
      default: ;
    endcase
  end

  // Stack and local writes
  always_ff @(posedge clk) begin
    if (fire) begin
      unique case (cmd.uop)
        UOP_PUSH_IMM: if (can_push) stk[depth[SW-1:0]] <= cmd.imm;
        UOP_PUSH_LOC: if (can_push) stk[depth[SW-1:0]] <= lval;
        UOP_STORE:    if (has1) loc[li] <= top;
        UOP_ADD:      if (has2) stk[dm2[SW-1:0]] <= sum;
        UOP_SUB:      if (has2) stk[dm2[SW-1:0]] <= dif;
        UOP_WRLOC:    loc[li] <= cmd.imm;
        default: ;
      endcase
    end
    if (rst) begin
      for (int i = 0; i < LOCAL_COUNT; i++) loc[i] <= '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) depth <= '0;
    else if (fire) depth <= depth_next;
  end

  assign res_valid = fire;

endmodule

// File: rtl/stack_bytecode_execute_unit_top.sv
`timescale 1ns / 1ps
// Path: an accepted transaction waits in the command queue, execute works on it combinationally
// and writes its result into the result queue, which drives the result ports.
// Throughput: one instruction per cycle while the result queue is not full.
// Reset (rst, synchronous): queues empty, stack depth zero, all locals zero.
// ----------------------------------------------------------------------------
// stack_bytecode_execute_unit_top: integer bytecode execute unit
// Decode front end, command queue, execute back end, result queue.
// ----------------------------------------------------------------------------
module stack_bytecode_execute_unit_top import sbeu_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int LOCAL_COUNT = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t req,
  output logic empty,
  input  logic pop,
  output res_t res
);

  cmd_t dec_cmd, q_cmd;
  logic q_empty, take, r_valid, r_full;
  res_t r_res;

  sbeu_decode #(.LOCAL_COUNT(LOCAL_COUNT)) u_dec (.req(req), .cmd(dec_cmd));

  sbeu_fifo #(.WIDTH($bits(cmd_t))) u_cq (
    .clk(clk), .rst(rst), .push(push), .din(dec_cmd), .full(full),
    .pop(take), .dout(q_cmd), .empty(q_empty)
  );

  sbeu_exec #(.STACK_DEPTH(STACK_DEPTH), .LOCAL_COUNT(LOCAL_COUNT)) u_exe (
    .clk(clk), .rst(rst), .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_take(take),
    .res_valid(r_valid), .res(r_res), .res_full(r_full)
  );

  sbeu_fifo #(.WIDTH($bits(res_t))) u_rq (
    .clk(clk), .rst(rst), .push(r_valid), .din(r_res), .full(r_full),
    .pop(pop), .dout(res), .empty(empty)
  );

endmodule
